### rtl/core/hbd_pkg.sv
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared widths, types and register indexes of the halfband decimator core.
// ----------------------------------------------------------------------------
package hbd_pkg;

   localparam int TAPS         = 15;
   localparam int SAMPLE_WIDTH = 16;
   localparam int COEF_WIDTH   = 16;

   localparam int NUM_CELLS = (TAPS - 1) / 2;
   localparam int NUM_PAIRS = (TAPS + 1) / 4;
   localparam int OUT_W     = 18;
   localparam int PAIR_W    = SAMPLE_WIDTH + 1;
   localparam int PROD_W    = PAIR_W + COEF_WIDTH;
   localparam int RND_W     = PROD_W - (COEF_WIDTH - 1);
   localparam int ACC_W     = (RND_W + 3 > OUT_W + 1) ? RND_W + 3 : OUT_W + 1;

   localparam int REQ_W     = ((4 * SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_W     = ((2 * OUT_W + 7) / 8) * 8;
   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_OUTER  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_SECOND = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_THIRD  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_INNER  = CSR_IDX_W'(3);

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] q;
      logic signed [SAMPLE_WIDTH-1:0] i;
   } cplx_type;

   typedef struct packed {
      logic signed [PAIR_W-1:0] q;
      logic signed [PAIR_W-1:0] i;
   } pair_type;

   typedef struct packed {
      logic signed [RND_W-1:0] q;
      logic signed [RND_W-1:0] i;
   } rnd_type;

endpackage

### rtl/core/hbd_cell.sv
// ----------------------------------------------------------------------------
// hbd_cell
// One history cell: holds two consecutive complex samples and takes the pair
// of its upstream neighbor on every accepted beat.
// ----------------------------------------------------------------------------
module hbd_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  hbd_pkg::cplx_type in_lo,
   input  hbd_pkg::cplx_type in_hi,
   output hbd_pkg::cplx_type out_lo,
   output hbd_pkg::cplx_type out_hi
);
   import hbd_pkg::*;

   cplx_type lo_ff, lo_in;
   cplx_type hi_ff, hi_in;

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (shift_en) begin
         lo_in = in_lo;
         hi_in = in_hi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= '0;
         hi_ff <= '0;
      end else begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   assign out_lo = lo_ff;
   assign out_hi = hi_ff;

endmodule

### rtl/core/hbd_prod.sv
// ----------------------------------------------------------------------------
// hbd_prod
// Weights one complex pair sum by a coefficient, rounds half up by a shift of
// COEF_WIDTH-1 and registers the result.
// ----------------------------------------------------------------------------
module hbd_prod (
   input  logic                                 clock,
   input  logic                                 enable,
   input  hbd_pkg::pair_type                    pair,
   input  logic signed [hbd_pkg::COEF_WIDTH-1:0] coef,
   output hbd_pkg::rnd_type                     rnd
);
   import hbd_pkg::*;

   localparam logic signed [PROD_W:0] ROUND = (PROD_W + 1)'(1) <<< (COEF_WIDTH - 2);

   logic signed [PROD_W:0] prod_i, prod_q;
   logic signed [PROD_W:0] shr_i, shr_q;
   rnd_type                rnd_ff, rnd_in;

   always_comb begin
      prod_i = (PROD_W + 1)'(pair.i * coef) + ROUND;
      prod_q = (PROD_W + 1)'(pair.q * coef) + ROUND;
      shr_i  = prod_i >>> (COEF_WIDTH - 1);
      shr_q  = prod_q >>> (COEF_WIDTH - 1);
      rnd_in = rnd_ff;
      if (enable) begin
         rnd_in.i = shr_i[RND_W-1:0];
         rnd_in.q = shr_q[RND_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rnd_ff <= rnd_in;
   end

   assign rnd = rnd_ff;

endmodule

### rtl/core/halfband_decimator_15_tap_complex_core.sv
// ----------------------------------------------------------------------------
// halfband_decimator_15_tap_complex_core
// Complex halfband decimator by two with 15 symmetric taps and four
// programmable weights, built on a row of history cells.
// ----------------------------------------------------------------------------
//  Channel   Dir  Beat carries
//  req_      in   first_i, first_q, second_i, second_q (one sample pair)
//  rsp_      out  out_i, out_q (one filtered sample)
//  csr_      in   csr_index, csr_data (coefficient write)
//
// One beat is taken every cycle while no result waits; a result is
// registered through the pair-sum, product and sum-and-saturate stages
// after its beat is accepted. The whole pipeline holds while a result waits.
// Reset clears the history cells, the weights and all valid flags.
// ----------------------------------------------------------------------------
module halfband_decimator_15_tap_complex_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // first_i, first_q, second_i, second_q
   input  logic [hbd_pkg::REQ_W-1:0]        req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_i, out_q, zero fill
   output logic [hbd_pkg::RSP_W-1:0]        rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hbd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hbd_pkg::COEF_WIDTH-1:0]   csr_data
);
   import hbd_pkg::*;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (OUT_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(2 ** (OUT_W - 1));

   logic     advance;
   logic     accept;
   cplx_type first, second;
   cplx_type cell_lo [NUM_CELLS+1];
   cplx_type cell_hi [NUM_CELLS+1];

   logic signed [COEF_WIDTH-1:0] coef_ff [NUM_PAIRS];
   logic signed [COEF_WIDTH-1:0] coef_in [NUM_PAIRS];

   pair_type pair_ff [NUM_PAIRS];
   pair_type pair_in [NUM_PAIRS];
   rnd_type  rnd [NUM_PAIRS];
   cplx_type center1_ff, center2_ff;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic signed [ACC_W-1:0] acc_i, acc_q;
   logic signed [OUT_W-1:0] sat_i, sat_q;
   logic [RSP_W-1:0]        data_ff, data_in;

   assign advance    = !v3_ff || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;
   assign csr_ready  = 1'b1;

   assign first.i  = req_tdata[SAMPLE_WIDTH-1:0];
   assign first.q  = req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
   assign second.i = req_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
   assign second.q = req_tdata[4*SAMPLE_WIDTH-1:3*SAMPLE_WIDTH];

   assign cell_lo[NUM_CELLS] = first;
   assign cell_hi[NUM_CELLS] = second;

   genvar c;
   generate
      for (c = 0; c < NUM_CELLS; c++) begin : g_cell
         hbd_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (accept),
            .in_lo    (cell_lo[c+1]),
            .in_hi    (cell_hi[c+1]),
            .out_lo   (cell_lo[c]),
            .out_hi   (cell_hi[c])
         );
      end
   endgenerate

   always_comb begin
      for (int k = 0; k < NUM_PAIRS; k++) begin
         coef_in[k] = coef_ff[k];
      end
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COEF_OUTER:  coef_in[0] = csr_data;
            CSR_COEF_SECOND: coef_in[1] = csr_data;
            CSR_COEF_THIRD:  coef_in[2] = csr_data;
            CSR_COEF_INNER:  coef_in[3] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_PAIRS; k++) begin
            coef_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < NUM_PAIRS; k++) begin
            coef_ff[k] <= coef_in[k];
         end
      end
   end

   // Pair k adds the even tap 2k to its mirror 14-2k; the newest tap is the
   // first sample of the incoming beat.
   genvar p;
   generate
      for (p = 0; p < NUM_PAIRS; p++) begin : g_pair
         always_comb begin
            pair_in[p] = pair_ff[p];
            if (advance) begin
               pair_in[p].i = PAIR_W'(cell_lo[p].i) + PAIR_W'(cell_lo[NUM_CELLS-p].i);
               pair_in[p].q = PAIR_W'(cell_lo[p].q) + PAIR_W'(cell_lo[NUM_CELLS-p].q);
            end
         end

         always_ff @(posedge clock) begin
            pair_ff[p] <= pair_in[p];
         end

         hbd_prod u_prod (
            .clock  (clock),
            .enable (advance),
            .pair   (pair_ff[p]),
            .coef   (coef_ff[p]),
            .rnd    (rnd[p])
         );
      end
   endgenerate

   always_comb begin
      acc_i = ACC_W'(center2_ff.i);
      acc_q = ACC_W'(center2_ff.q);
      for (int k = 0; k < NUM_PAIRS; k++) begin
         acc_i = acc_i + ACC_W'(rnd[k].i);
         acc_q = acc_q + ACC_W'(rnd[k].q);
      end
      if (acc_i > SAT_HI) begin
         sat_i = SAT_HI[OUT_W-1:0];
      end else if (acc_i < SAT_LO) begin
         sat_i = SAT_LO[OUT_W-1:0];
      end else begin
         sat_i = acc_i[OUT_W-1:0];
      end
      if (acc_q > SAT_HI) begin
         sat_q = SAT_HI[OUT_W-1:0];
      end else if (acc_q < SAT_LO) begin
         sat_q = SAT_LO[OUT_W-1:0];
      end else begin
         sat_q = acc_q[OUT_W-1:0];
      end
      data_in = data_ff;
      v1_in   = v1_ff;
      v2_in   = v2_ff;
      v3_in   = v3_ff;
      if (advance) begin
         data_in = {(RSP_W - 2 * OUT_W)'(0), sat_q, sat_i};
         v1_in   = req_tvalid;
         v2_in   = v1_ff;
         v3_in   = v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         center1_ff <= cell_hi[(NUM_CELLS - 1) / 2];
         center2_ff <= center1_ff;
      end
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = data_ff;

endmodule

### rtl/core/hbd_checker.sv
// ----------------------------------------------------------------------------
// hbd_checker
// Port-level checks of the halfband decimator core, bound to the top level.
// ----------------------------------------------------------------------------
module hbd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [hbd_pkg::RSP_W-1:0]        rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a stalled result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tready ##1 rsp_tready ##1 rsp_tready
      |=> rsp_tvalid)
      else $error("accepted beat produced no result in three cycles");

endmodule

bind halfband_decimator_15_tap_complex_core hbd_checker u_hbd_checker (.*);

### sim/halfband_decimator_15_tap_complex_core_tb.sv
// ----------------------------------------------------------------------------
// halfband_decimator_15_tap_complex_core_tb
// Drives sample-pair beats into the decimator core and predicts each
// filtered I/Q output from a local copy of the history and the weights.
// Each output beat is compared with the oldest prediction. The run covers
// edge values, saturation, writes to unused register indexes, and random
// streams under several weight settings, most with random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module halfband_decimator_15_tap_complex_core_tb;

   import hbd_pkg::*;

   localparam int HIST_DEPTH  = TAPS - 1;
   localparam int CENTER      = 7;
   localparam int NUM_WEIGHTS = 4;
   localparam int LATENCY     = 3;
   localparam int OUT_MAX     = 131071;
   localparam int OUT_MIN     = -131072;

   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (COEF_WIDTH - 2);
   localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = 16'sh8000;
   localparam logic [COEF_WIDTH-1:0] W_MAX = 16'h7FFF;
   localparam logic [COEF_WIDTH-1:0] W_MIN = 16'h8000;

   typedef logic [HIST_DEPTH-1:0][SAMPLE_WIDTH-1:0] hist_type;
   typedef logic [TAPS-1:0][SAMPLE_WIDTH-1:0] window_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] q;
      logic signed [OUT_W-1:0] i;
   } iq_out_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COEF_WIDTH-1:0] csr_data = '0;

   halfband_decimator_15_tap_complex_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   logic [NUM_WEIGHTS-1:0][COEF_WIDTH-1:0] weights = '0;
   hist_type   hist_i = '0;
   hist_type   hist_q = '0;
   iq_out_type expected_outputs[$];

   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;
   int beats_sent     = 0;
   int outputs_seen   = 0;
   int weight_sets    = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic logic signed [OUT_W-1:0] filter_lane(
      hist_type hist, logic signed [SAMPLE_WIDTH-1:0] newest);
      window_type               win;
      logic signed [PAIR_W-1:0] pair_sum;
      logic signed [PROD_W-1:0] prod;
      logic signed [RND_W-1:0]  rounded;
      logic signed [ACC_W-1:0]  acc;
      win = {newest, hist};
      acc = ACC_W'($signed(win[CENTER]));
      for (int k = 0; k < NUM_WEIGHTS; k++) begin
         pair_sum = PAIR_W'($signed(win[2*k])) + PAIR_W'($signed(win[TAPS-1-2*k]));
         prod     = PROD_W'(pair_sum) * PROD_W'($signed(weights[k]));
         rounded  = RND_W'((prod + ROUND_HALF) >>> (COEF_WIDTH - 1));
         acc      = acc + ACC_W'(rounded);
      end
      if (acc > OUT_MAX) acc = ACC_W'(OUT_MAX);
      if (acc < OUT_MIN) acc = ACC_W'(OUT_MIN);
      return acc[OUT_W-1:0];
   endfunction

   function automatic void predict_output(cplx_type first, cplx_type second);
      iq_out_type result;
      result.i = filter_lane(hist_i, first.i);
      result.q = filter_lane(hist_q, first.q);
      expected_outputs.push_back(result);
      hist_i = {second.i, first.i, hist_i[HIST_DEPTH-1:2]};
      hist_q = {second.q, first.q, hist_q[HIST_DEPTH-1:2]};
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      iq_out_type got;
      iq_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[2*OUT_W-1:0];
         outputs_seen++;
         if (expected_outputs.size() == 0) begin
            report_mismatch("unexpected output beat", got.i, 0);
         end else begin
            want = expected_outputs.pop_front();
            if (got.i !== want.i) report_mismatch("out_i", got.i, want.i);
            if (got.q !== want.q) report_mismatch("out_q", got.q, want.q);
            if (rsp_tdata[RSP_W-1:2*OUT_W] !== '0) begin
               report_mismatch("zero fill", rsp_tdata[RSP_W-1:2*OUT_W], 0);
            end
         end
      end
   end

   task automatic send_pair(cplx_type first, cplx_type second);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {second, first};
      do @(posedge clock); while (!req_tready);
      predict_output(first, second);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      while (expected_outputs.size() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [COEF_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (index < NUM_WEIGHTS) weights[index] = data;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_weights(logic [COEF_WIDTH-1:0] w_outer, logic [COEF_WIDTH-1:0] w_second,
                                  logic [COEF_WIDTH-1:0] w_third, logic [COEF_WIDTH-1:0] w_inner);
      drain_outputs();
      write_reg(CSR_COEF_OUTER, w_outer);
      write_reg(CSR_COEF_SECOND, w_second);
      write_reg(CSR_COEF_THIRD, w_third);
      write_reg(CSR_COEF_INNER, w_inner);
      weight_sets++;
   endtask

   function automatic logic [COEF_WIDTH-1:0] rand_weight();
      return COEF_WIDTH'($urandom_range(65535));
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] rand_sample();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) return SAMPLE_WIDTH'($urandom_range(65535));
      if (pick < 70) begin
         case ($urandom_range(3))
            0: return S_MAX;
            1: return S_MIN;
            2: return '0;
            default: return '1;
         endcase
      end
      return SAMPLE_WIDTH'($signed($urandom_range(511)) - 256);
   endfunction

   function automatic cplx_type rand_cplx();
      cplx_type s;
      s.i = rand_sample();
      s.q = rand_sample();
      return s;
   endfunction

   task automatic test_center_path();
      cplx_type a;
      cplx_type b;
      a = '{q: S_MIN, i: S_MAX};
      b = '{q: '0, i: '1};
      send_pair(a, b);
      send_pair(b, a);
      send_pair('{q: 16'sh5555, i: 16'shAAAA}, '{q: 16'sh0001, i: 16'sh8001});
      send_pair('{q: 16'shAAAA, i: 16'sh5555}, a);
      send_pair(b, '{q: S_MAX, i: S_MIN});
      drain_outputs();
   endtask

   task automatic test_saturation();
      cplx_type hi;
      cplx_type lo;
      hi = '{q: S_MAX, i: S_MAX};
      lo = '{q: S_MIN, i: S_MIN};
      program_weights(W_MAX, W_MAX, W_MAX, W_MAX);
      repeat (7) send_pair(hi, hi);
      repeat (7) send_pair(lo, lo);
      drain_outputs();
   endtask

   task automatic test_unused_index();
      program_weights(W_MIN, W_MIN, W_MIN, W_MIN);
      write_reg(CSR_IDX_W'(NUM_WEIGHTS), 16'h1234);
      write_reg('1, 16'h7FFF);
      write_reg(CSR_IDX_W'($urandom_range(255, NUM_WEIGHTS)), 16'h0F0F);
      repeat (3) send_pair('{q: S_MIN, i: S_MAX}, '{q: S_MAX, i: S_MIN});
      drain_outputs();
   endtask

   task automatic test_random_stream(int count, int gap_pct, int stall_pct, bit pause_once);
      int pause_at;
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
      pause_at       = $urandom_range(count - 20, 20);
      for (int n = 0; n < count; n++) begin
         if (pause_once && n == pause_at) drain_outputs();
         send_pair(rand_cplx(), rand_cplx());
      end
      drain_outputs();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_center_path();
      test_saturation();
      test_unused_index();

      program_weights(rand_weight(), rand_weight(), rand_weight(), rand_weight());
      test_random_stream(140, 34, 63, 1'b1);
      program_weights(16'hFC18, 16'h0BB8, 16'hDCD8, 16'h4E20);
      test_random_stream(130, 34, 63, 1'b0);

      program_weights(W_MIN, W_MAX, W_MIN, W_MAX);
      test_random_stream(130, 63, 34, 1'b0);
      program_weights(rand_weight(), rand_weight(), rand_weight(), rand_weight());
      test_random_stream(140, 63, 34, 1'b1);

      program_weights(16'h0000, W_MAX, 16'h0000, W_MIN);
      test_random_stream(130, 0, 0, 1'b0);
      program_weights(rand_weight(), rand_weight(), rand_weight(), rand_weight());
      test_random_stream(130, 0, 0, 1'b1);

      repeat (LATENCY + 10) @(negedge clock);
      if (expected_outputs.size() != 0) begin
         report_mismatch("outputs still missing", 0, expected_outputs.size());
      end

      $display("Sent %0d sample-pair beats and checked %0d output beats.",
               beats_sent, outputs_seen);
      $display("Used %0d weight settings, including saturation and unused-index writes.",
               weight_sets);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/hbd_pkg.sv
rtl/core/hbd_cell.sv
rtl/core/hbd_prod.sv
rtl/core/halfband_decimator_15_tap_complex_core.sv
rtl/core/hbd_checker.sv
sim/halfband_decimator_15_tap_complex_core_tb.sv
